@@ rtl/core/rlg_pkg.sv @@
package rlg_pkg;

  localparam int LINE_BYTES_DEF = 2048;

  localparam int OFFSET_W = 13;
  localparam int LENGTH_W = 15;
  localparam int POS_W    = 16;
  localparam int IDX_W    = 11;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 15;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_COMMIT = 2'd1;
  localparam logic [1:0] OP_DIR    = 2'd2;
  localparam logic [1:0] OP_POS    = 2'd3;

  localparam logic [CFG_IW-1:0] CFG_WINDOW_OFFSET = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LINE_LENGTH   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_FORWARD_ONLY  = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_IDLE_LEVEL    = 2'd3;

  localparam logic PIXEL_DARK = 1'b0;

  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        byte_index;
    logic [7:0]              byte_value;
    logic                    direction;
    logic signed [POS_W-1:0] position;
  } in_t;

  typedef struct packed {
    logic fire_pulse;
    logic scan_enabled;
  } out_t;

  // decision context carried alongside the memory read
  typedef struct packed {
    logic       is_pos;
    logic       in_win;
    logic       byte_ok;
    logic [2:0] bit_sel;
    logic       idle;
    logic       en;
  } s1_ctrl_t;

endpackage

@@ rtl/core/rlg_line_mem.sv @@
module rlg_line_mem #(
  parameter int MEM_AW = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [MEM_AW-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [MEM_AW-1:0] rd_addr,
  output logic [7:0]        rd_data_r
);

  localparam int DEPTH = 1 << MEM_AW;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/rlg_front.sv @@
module rlg_front #(
  parameter int LINE_BYTES = rlg_pkg::LINE_BYTES_DEF,
  parameter int MEM_AW     = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  rlg_pkg::in_t              in_data,
  input  logic                      s1_free,
  output logic                      in_ready,
  input  logic                      cfg_we,
  input  logic [rlg_pkg::CFG_IW-1:0] cfg_index,
  input  logic [rlg_pkg::CFG_DW-1:0] cfg_data,
  output logic                      mem_wr_en,
  output logic [MEM_AW-1:0]         mem_wr_addr,
  output logic [7:0]                mem_wr_data,
  output logic                      mem_rd_en,
  output logic [MEM_AW-1:0]         mem_rd_addr,
  output logic                      s1_load,
  output rlg_pkg::s1_ctrl_t         s1_ctrl
);

  import rlg_pkg::*;

  localparam int BANK_AW = MEM_AW - 1;

  logic [OFFSET_W-1:0] offset_r;
  logic [LENGTH_W-1:0] length_r;
  logic                fwd_only_r;
  logic                idle_r;
  logic                bank_r;
  logic                bank_nxt;
  logic                en_r;
  logic                en_nxt;
  logic                clr_busy_r;
  logic [MEM_AW-1:0]   clr_addr_r;

  logic                accept;
  logic [31:0]         idx_ext;
  logic                idx_ok;
  logic signed [17:0]  pos_ext;
  logic signed [17:0]  lo;
  logic signed [17:0]  hi;
  logic signed [17:0]  pix;
  logic [31:0]         pix_byte;
  logic                in_win;

  assign in_ready = !clr_busy_r && s1_free;
  assign accept   = in_valid && in_ready;
  assign s1_load  = accept;

  assign idx_ext = 32'(in_data.byte_index);
  assign idx_ok  = idx_ext < 32'(LINE_BYTES);

  assign pos_ext  = 18'(in_data.position);
  assign lo       = signed'({5'd0, offset_r});
  assign hi       = lo + signed'({3'd0, length_r});
  assign in_win   = (pos_ext >= lo) && (pos_ext < hi);
  assign pix      = pos_ext - lo;
  assign pix_byte = 32'(pix[14:3]);

  // sweep zeros through the store after reset, then take load words
  always_comb begin
    if (clr_busy_r) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr_r;
      mem_wr_data = 8'd0;
    end else begin
      mem_wr_en   = accept && (in_data.op == OP_LOAD) && idx_ok;
      mem_wr_addr = {~bank_r, idx_ext[BANK_AW-1:0]};
      mem_wr_data = in_data.byte_value;
    end
  end

  assign mem_rd_en   = accept;
  assign mem_rd_addr = {bank_r, pix_byte[BANK_AW-1:0]};

  always_comb begin
    bank_nxt = bank_r;
    en_nxt   = en_r;
    if (accept) begin
      case (in_data.op)
        OP_COMMIT: bank_nxt = ~bank_r;
        OP_DIR:    en_nxt   = fwd_only_r ? in_data.direction : 1'b1;
        default:   ;
      endcase
    end
  end

  always_comb begin
    s1_ctrl.is_pos  = in_data.op == OP_POS;
    s1_ctrl.in_win  = in_win;
    s1_ctrl.byte_ok = pix_byte < 32'(LINE_BYTES);
    s1_ctrl.bit_sel = pix[2:0];
    s1_ctrl.idle    = idle_r;
    s1_ctrl.en      = en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= '0;
      length_r   <= '0;
      fwd_only_r <= 1'b0;
      idle_r     <= 1'b0;
      bank_r     <= 1'b0;
      en_r       <= 1'b1;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      bank_r <= bank_nxt;
      en_r   <= en_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_OFFSET: offset_r   <= cfg_data[OFFSET_W-1:0];
          CFG_LINE_LENGTH:   length_r   <= cfg_data[LENGTH_W-1:0];
          CFG_FORWARD_ONLY:  fwd_only_r <= cfg_data[0];
          CFG_IDLE_LEVEL:    idle_r     <= cfg_data[0];
          default:           ;
        endcase
      end
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !accept)
    else $error("word accepted during store clear");

  a_commit_swaps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.op == OP_COMMIT) |=> bank_r != $past(bank_r))
    else $error("commit did not swap banks");

  a_dir_free_enables: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.op == OP_DIR) && !fwd_only_r |=> en_r)
    else $error("direction word left scan disabled");

endmodule

@@ rtl/core/rlg_pick.sv @@
module rlg_pick (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_load,
  input  rlg_pkg::s1_ctrl_t s1_ctrl,
  input  logic [7:0]        rd_data,
  output logic              s1_free,
  output logic              out_valid,
  input  logic              out_ready,
  output rlg_pkg::out_t     out_data
);

  import rlg_pkg::*;

  logic     s1_v_r;
  s1_ctrl_t s1_c_r;
  logic     out_v_r;
  out_t     out_r;
  logic     s1_adv;
  logic     pix_bit;
  out_t     res;

  assign s1_adv  = s1_v_r && (!out_v_r || out_ready);
  assign s1_free = !s1_v_r || s1_adv;

  assign pix_bit = s1_c_r.byte_ok && rd_data[s1_c_r.bit_sel];

  always_comb begin
    res.scan_enabled = s1_c_r.en;
    if (s1_c_r.is_pos) begin
      res.fire_pulse = s1_c_r.en && (s1_c_r.in_win ? pix_bit : s1_c_r.idle);
    end else begin
      res.fire_pulse = PIXEL_DARK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_c_r <= s1_ctrl;
    end
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_ready |-> !s1_free)
    else $error("pipeline took a word while both stages were held");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r)
    else $error("held word dropped from read stage");

  a_quiet_fire: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_c_r.is_pos |=> !out_r.fire_pulse)
    else $error("pulse on a non-position word");

endmodule

@@ rtl/core/raster_line_laser_gate.sv @@
// Double-banked raster line store with laser pulse gating. Load words write a bitmap
// byte into the back bank, commit words swap the banks, direction words update the scan
// enable, and position words look up one pixel of the front bank (LSB first) inside the
// window [window_offset, window_offset + line_length), giving idle_level outside it.
// Every word yields one result. One word is taken per cycle while out_ready does not
// hold the output back; its result passes through the synchronous line memory read
// at the accepting edge and then the output register, which drives out_valid. After
// reset the store, 2 * 2**clog2(LINE_BYTES) bytes (4096 at the default size), is zeroed
// one byte per cycle with in_ready low; configuration writes are taken throughout.
module raster_line_laser_gate #(
  parameter int LINE_BYTES = rlg_pkg::LINE_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rlg_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rlg_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [rlg_pkg::CFG_IW-1:0] cfg_index,
  input  logic [rlg_pkg::CFG_DW-1:0] cfg_data
);

  import rlg_pkg::*;

  localparam int MEM_AW = $clog2(LINE_BYTES) + 1;

  logic              mem_wr_en;
  logic [MEM_AW-1:0] mem_wr_addr;
  logic [7:0]        mem_wr_data;
  logic              mem_rd_en;
  logic [MEM_AW-1:0] mem_rd_addr;
  logic [7:0]        mem_rd_data;
  logic              s1_load;
  logic              s1_free;
  s1_ctrl_t          s1_ctrl;

  rlg_front #(
    .LINE_BYTES (LINE_BYTES),
    .MEM_AW     (MEM_AW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .s1_free     (s1_free),
    .in_ready    (in_ready),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .s1_load     (s1_load),
    .s1_ctrl     (s1_ctrl)
  );

  rlg_line_mem #(
    .MEM_AW (MEM_AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_en     (mem_rd_en),
    .rd_addr   (mem_rd_addr),
    .rd_data_r (mem_rd_data)
  );

  rlg_pick u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_load   (s1_load),
    .s1_ctrl   (s1_ctrl),
    .rd_data   (mem_rd_data),
    .s1_free   (s1_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rlg_pkg::*;

  localparam int LINE_BYTES  = LINE_BYTES_DEF;
  localparam int LIMIT_CYCLES = 400000;

  class laser_gate_ledger;
    logic [7:0]          line_mem [2*LINE_BYTES];
    bit                  front;
    bit                  scan_en;
    logic [OFFSET_W-1:0] win_offset;
    logic [LENGTH_W-1:0] win_length;
    bit                  fwd_only;
    bit                  idle_lvl;
    out_t                pulses_due [$];
    int                  mismatches;

    function new();
      foreach (line_mem[i]) line_mem[i] = 8'h00;
      front = 1'b0;
      scan_en = 1'b1;
      win_offset = '0;
      win_length = '0;
      fwd_only = 1'b0;
      idle_lvl = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, int value);
      case (idx)
        CFG_WINDOW_OFFSET: win_offset = OFFSET_W'(value);
        CFG_LINE_LENGTH:   win_length = LENGTH_W'(value);
        CFG_FORWARD_ONLY:  fwd_only = value[0];
        CFG_IDLE_LEVEL:    idle_lvl = value[0];
        default: ;
      endcase
    endfunction

    function bit beam_lit(logic signed [POS_W-1:0] pos);
      int lo;
      int hi;
      int pix;
      lo = int'(win_offset);
      hi = lo + int'(win_length);
      if (int'(pos) < lo || int'(pos) >= hi) return idle_lvl;
      pix = int'(pos) - lo;
      // pixels past the end of the bank read as dark
      if ((pix >> 3) >= LINE_BYTES) return PIXEL_DARK;
      return line_mem[int'(front) * LINE_BYTES + (pix >> 3)][pix & 7];
    endfunction

    function void take_word(in_t w);
      out_t r;
      r.fire_pulse = 1'b0;
      case (w.op)
        OP_LOAD: begin
          if (int'(w.byte_index) < LINE_BYTES)
            line_mem[int'(!front) * LINE_BYTES + int'(w.byte_index)] = w.byte_value;
        end
        OP_COMMIT: front = !front;
        OP_DIR:    scan_en = fwd_only ? w.direction : 1'b1;
        default:   r.fire_pulse = scan_en && beam_lit(w.position);
      endcase
      r.scan_enabled = scan_en;
      pulses_due.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pulses_due.size() == 0) begin
        $error("unexpected result: fire_pulse %0b scan_enabled %0b",
               got.fire_pulse, got.scan_enabled);
        mismatches++;
        return;
      end
      want = pulses_due.pop_front();
      if (got.fire_pulse !== want.fire_pulse) begin
        $error("fire_pulse: expected %0b, actual %0b", want.fire_pulse, got.fire_pulse);
        mismatches++;
      end
      if (got.scan_enabled !== want.scan_enabled) begin
        $error("scan_enabled: expected %0b, actual %0b", want.scan_enabled, got.scan_enabled);
        mismatches++;
      end
    endfunction

    function int pending();
      return pulses_due.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_we = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_data = '0;

  laser_gate_ledger    ledger;
  int                  send_idle_pct = 19;
  int                  recv_idle_pct = 86;
  int                  win_lo = 0;
  int                  win_len = 0;
  int                  cycles = 0;

  raster_line_laser_gate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("raster_line_laser_gate: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // outputs are stable between edges, so the negedge view equals the accepting edge
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.check_result(out_data);
  end

  function automatic in_t mk(logic [1:0] op, int idx, int value, bit dir, int pos);
    in_t w;
    w.op = op;
    w.byte_index = IDX_W'(idx);
    w.byte_value = 8'(value);
    w.direction = dir;
    w.position = POS_W'(pos);
    return w;
  endfunction

  function automatic in_t random_word();
    in_t w;
    int  r;
    int  span;
    w.op = 2'($urandom);
    w.byte_index = IDX_W'($urandom);
    w.byte_value = 8'($urandom);
    w.direction = 1'($urandom);
    w.position = POS_W'($urandom);
    span = (win_len + 7) / 8;
    if (span < 1) span = 1;
    if (span > LINE_BYTES) span = LINE_BYTES;
    r = $urandom_range(99);
    if (r < 30) begin
      w.op = OP_LOAD;
      // mostly fill the bytes that the window actually reads
      if ($urandom_range(3) != 0) w.byte_index = IDX_W'($urandom_range(span - 1));
    end else if (r < 36) begin
      w.op = OP_COMMIT;
    end else if (r < 46) begin
      w.op = OP_DIR;
    end else begin
      w.op = OP_POS;
      if ($urandom_range(4) != 0) w.position = POS_W'(win_lo - 8 + int'($urandom_range(win_len + 15)));
    end
    return w;
  endfunction

  task automatic send_word(in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    ledger.take_word(w);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DW'(value);
    ledger.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_settings(int off, int len, bit fwd, bit idl);
    write_reg(CFG_WINDOW_OFFSET, off);
    write_reg(CFG_LINE_LENGTH, len);
    write_reg(CFG_FORWARD_ONLY, int'(fwd));
    write_reg(CFG_IDLE_LEVEL, int'(idl));
    cfg_we <= 1'b0;
    win_lo = off;
    win_len = len;
  endtask

  initial begin
    int off;
    int len;
    bit fwd;
    bit idl;
    ledger = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty window, idle level low, enable stays high
    send_word(mk(OP_POS, 0, 0, 1'b0, 0));
    send_word(mk(OP_DIR, 0, 0, 1'b0, 0));
    settle();

    apply_settings(8, 40, 1'b1, 1'b1);
    send_word(mk(OP_LOAD, 0, 8'hA5, 1'b0, 0));
    send_word(mk(OP_LOAD, 4, 8'h80, 1'b0, 0));
    send_word(mk(OP_LOAD, 2047, 8'hFF, 1'b1, -1));
    send_word(mk(OP_POS, 0, 0, 1'b0, 8));
    send_word(mk(OP_COMMIT, 0, 0, 1'b0, 0));
    send_word(mk(OP_POS, 0, 0, 1'b0, 8));
    send_word(mk(OP_POS, 0, 0, 1'b0, 9));
    send_word(mk(OP_POS, 0, 0, 1'b0, 7));
    send_word(mk(OP_POS, 0, 0, 1'b0, 47));
    send_word(mk(OP_POS, 0, 0, 1'b0, 48));
    send_word(mk(OP_POS, 2047, 255, 1'b1, -32768));
    send_word(mk(OP_POS, 0, 0, 1'b0, 32767));
    send_word(mk(OP_DIR, 0, 0, 1'b0, 0));
    send_word(mk(OP_POS, 0, 0, 1'b0, 8));
    send_word(mk(OP_DIR, 0, 0, 1'b1, 0));
    send_word(mk(OP_LOAD, 0, 8'h00, 1'b0, 0));
    send_word(mk(OP_COMMIT, 0, 0, 1'b0, 0));
    send_word(mk(OP_POS, 0, 0, 1'b0, 8));
    send_word(mk(OP_COMMIT, 0, 0, 1'b0, 0));
    send_word(mk(OP_POS, 0, 0, 1'b0, 15));
    settle();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin off = 3;    len = 64;    fwd = 1'b0; idl = 1'b1; end
        1: begin off = 0;    len = 16384; fwd = 1'b1; idl = 1'b0; end
        // window reaches past the bank and beyond any position
        2: begin off = 8191; len = 32767; fwd = 1'b1; idl = 1'b1; end
        3: begin off = 4096; len = 0;     fwd = 1'b0; idl = 1'b1; end
        4: begin
          off = $urandom_range(4096);
          len = $urandom_range(600, 1);
          fwd = 1'($urandom);
          idl = 1'($urandom);
        end
        default: begin off = 17; len = 200; fwd = 1'b1; idl = 1'b0; end
      endcase
      if (seg < 2) begin
        send_idle_pct = 19;
        recv_idle_pct = 86;
      end else if (seg < 4) begin
        send_idle_pct = 86;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_settings(off, len, fwd, idl);
      for (int n = 0; n < 300; n++) send_word(random_word());
      settle();
    end

    repeat (8) @(posedge clk);
    if (ledger.mismatches == 0)
      $display("raster_line_laser_gate: match");
    else
      $display("raster_line_laser_gate: mismatch");
    $finish;
  end

endmodule
